// File: design/dtoi_pkg.sv
// Shared types, operation codes and helpers for the divider/timer block.
package dtoi_pkg;

  localparam int MaxTickCycles = 8;
  localparam int CntW          = $clog2(MaxTickCycles + 1);

  // Operation codes carried on func
  localparam logic [3:0] FUNC_TICK    = 4'd0;
  localparam logic [3:0] FUNC_RD_DIV  = 4'd1;
  localparam logic [3:0] FUNC_WR_DIV  = 4'd2;
  localparam logic [3:0] FUNC_RD_TIMA = 4'd3;
  localparam logic [3:0] FUNC_WR_TIMA = 4'd4;
  localparam logic [3:0] FUNC_RD_TMA  = 4'd5;
  localparam logic [3:0] FUNC_WR_TMA  = 4'd6;
  localparam logic [3:0] FUNC_RD_TAC  = 4'd7;
  localparam logic [3:0] FUNC_WR_TAC  = 4'd8;
  localparam logic [3:0] FUNC_SET_CNT = 4'd9;

  // Divider advance per machine cycle
  localparam logic [15:0] DivStep = 16'd4;

  // Timer clock select codes (low two bits of the control register)
  localparam logic [1:0] SEL_BIT9 = 2'd0;
  localparam logic [1:0] SEL_BIT3 = 2'd1;
  localparam logic [1:0] SEL_BIT5 = 2'd2;
  localparam logic [1:0] SEL_BIT7 = 2'd3;

  // One command from the sequencer to the timer core
  typedef struct packed {
    logic        clr_flag;  // start of a tick: drop the reloaded flag
    logic        mcycle;    // run one machine cycle
    logic        access;    // perform the register access in func
    logic [3:0]  func;
    logic [15:0] wdata;
  } cmd_t;

  // Gated timer clock input for a given divider value and control byte
  function automatic logic timer_input(logic [15:0] div, logic [7:0] tac);
    logic b;
    case (tac[1:0])
      SEL_BIT9: b = div[9];
      SEL_BIT3: b = div[3];
      SEL_BIT5: b = div[5];
      SEL_BIT7: b = div[7];
      default:  b = 1'b0;
    endcase
    return tac[2] & b;
  endfunction

endpackage

// File: design/dtoi_core.sv
// Timer core: divider, TIMA/TMA/TAC registers and the one-step update unit.
module dtoi_core (
  input  logic              clk,
  input  logic              rst,
  input  dtoi_pkg::cmd_t    cmd,
  output logic [7:0]        rdata,
  output logic              step_irq
);

  logic [15:0] div_counter, div_counter_next;
  logic [7:0]  timer_count, timer_count_next;
  logic [7:0]  timer_modulo, timer_modulo_next;
  logic [7:0]  timer_control, timer_control_next;
  logic        prev_tick_input, prev_tick_input_next;
  logic        reload_pending, reload_pending_next;
  logic        reloaded_this_tick, reloaded_this_tick_next;

  // shared edge unit operands
  logic [15:0] edge_div;
  logic [7:0]  edge_tac;
  logic [7:0]  edge_tc;
  logic        edge_rp;
  logic        now_in;
  logic        fall;
  logic [7:0]  tc_inc;

  always_comb begin
    // operand select for the falling-edge / increment unit
    edge_div = div_counter;
    edge_tac = timer_control;
    edge_tc  = timer_count;
    edge_rp  = reload_pending;
    if (cmd.mcycle) begin
      edge_div = div_counter + dtoi_pkg::DivStep;
      if (reload_pending) begin
        edge_tc = timer_modulo;
        edge_rp = 1'b0;
      end
    end else if (cmd.func == dtoi_pkg::FUNC_WR_DIV) begin
      edge_div = '0;
    end else if (cmd.func == dtoi_pkg::FUNC_SET_CNT) begin
      edge_div = cmd.wdata;
    end else if (cmd.func == dtoi_pkg::FUNC_WR_TAC) begin
      edge_tac = cmd.wdata[7:0];
    end
    now_in = dtoi_pkg::timer_input(edge_div, edge_tac);
    fall   = prev_tick_input & ~now_in;
    tc_inc = edge_tc + 8'd1;
  end

  always_comb begin
    div_counter_next        = div_counter;
    timer_count_next        = timer_count;
    timer_modulo_next       = timer_modulo;
    timer_control_next      = timer_control;
    prev_tick_input_next    = prev_tick_input;
    reload_pending_next     = reload_pending;
    reloaded_this_tick_next = reloaded_this_tick;
    step_irq                = 1'b0;
    rdata                   = '0;

    if (cmd.clr_flag) begin
      reloaded_this_tick_next = 1'b0;
    end else if (cmd.mcycle) begin
      step_irq = reload_pending;
      if (reload_pending) begin
        reloaded_this_tick_next = 1'b1;
      end
      div_counter_next     = edge_div;
      prev_tick_input_next = now_in;
      timer_count_next     = fall ? tc_inc : edge_tc;
      reload_pending_next  = fall ? (tc_inc == 8'd0) : edge_rp;
    end else if (cmd.access) begin
      case (cmd.func)
        dtoi_pkg::FUNC_RD_DIV:  rdata = div_counter[15:8];
        dtoi_pkg::FUNC_RD_TIMA: rdata = timer_count;
        dtoi_pkg::FUNC_RD_TMA:  rdata = timer_modulo;
        dtoi_pkg::FUNC_RD_TAC:  rdata = timer_control;
        dtoi_pkg::FUNC_WR_DIV, dtoi_pkg::FUNC_WR_TAC: begin
          div_counter_next     = edge_div;
          timer_control_next   = edge_tac;
          prev_tick_input_next = now_in;
          if (fall) begin
            timer_count_next = tc_inc;
            if (tc_inc == 8'd0) begin
              reload_pending_next = 1'b1;
            end
          end
        end
        dtoi_pkg::FUNC_WR_TIMA: begin
          if (!reloaded_this_tick) begin
            reload_pending_next = 1'b0;
            timer_count_next    = cmd.wdata[7:0];
          end
        end
        dtoi_pkg::FUNC_WR_TMA: begin
          if (reloaded_this_tick) begin
            timer_count_next = cmd.wdata[7:0];
          end
          timer_modulo_next = cmd.wdata[7:0];
        end
        dtoi_pkg::FUNC_SET_CNT: begin
          div_counter_next     = edge_div;
          prev_tick_input_next = now_in;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_counter        <= '0;
      timer_count        <= '0;
      timer_modulo       <= '0;
      timer_control      <= '0;
      prev_tick_input    <= 1'b0;
      reload_pending     <= 1'b0;
      reloaded_this_tick <= 1'b0;
    end else begin
      div_counter        <= div_counter_next;
      timer_count        <= timer_count_next;
      timer_modulo       <= timer_modulo_next;
      timer_control      <= timer_control_next;
      prev_tick_input    <= prev_tick_input_next;
      reload_pending     <= reload_pending_next;
      reloaded_this_tick <= reloaded_this_tick_next;
    end
  end

endmodule

// File: design/dtoi_seq.sv
// Sequencer: takes a request, steps the core one machine cycle at a time.
module dtoi_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3:0]               func,
  input  logic [3:0]               tick_count,
  input  logic [15:0]              wdata,
  input  logic                     out_free,
  output logic                     accept,
  output logic                     done,
  output dtoi_pkg::cmd_t           cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                      state, state_next;
  logic [3:0]                cur_func;
  logic [15:0]               cur_wdata;
  logic [dtoi_pkg::CntW-1:0] remain, remain_next;
  logic [dtoi_pkg::CntW-1:0] sat_cnt;
  logic                      is_tick;

  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign is_tick  = (cur_func == dtoi_pkg::FUNC_TICK);

  always_comb begin
    if (32'(tick_count) > dtoi_pkg::MaxTickCycles) begin
      sat_cnt = dtoi_pkg::CntW'(dtoi_pkg::MaxTickCycles);
    end else begin
      sat_cnt = dtoi_pkg::CntW'(tick_count);
    end
  end

  always_comb begin
    state_next    = state;
    remain_next   = remain;
    done          = 1'b0;
    cmd.clr_flag  = 1'b0;
    cmd.mcycle    = 1'b0;
    cmd.access    = 1'b0;
    cmd.func      = cur_func;
    cmd.wdata     = cur_wdata;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          // a tick drops the reloaded flag as it is taken
          cmd.clr_flag = (func == dtoi_pkg::FUNC_TICK);
          remain_next  = sat_cnt;
          state_next   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (is_tick) begin
          if (remain == '0) begin
            done       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.mcycle  = 1'b1;
            remain_next = remain - 1'b1;
            if (remain == dtoi_pkg::CntW'(1)) begin
              done       = 1'b1;
              state_next = ST_IDLE;
            end
          end
        end else begin
          cmd.access = 1'b1;
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      remain <= '0;
    end else begin
      state  <= state_next;
      remain <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_func  <= func;
      cur_wdata <= wdata;
    end
  end

endmodule

// File: design/divider_timer_overflow_irq.sv
// Top level of the divider/timer block: sequencer, timer core, result register.
//
// Each request is either a tick of machine cycles or one register access to
// DIV, TIMA, TMA or TAC (plus a direct load of the 16-bit divider). Requests
// are handled one at a time by a small sequencer driving a single update
// unit in the timer core, which applies one machine cycle or one access per
// clock. A tick of n machine cycles (n capped at 8) is run as n machine
// cycles after acceptance, and its result is then loaded into the output
// register; a tick of zero cycles runs no machine cycle, and an access is
// applied in a single step. in_ready drops while a request is in work, and
// also while the previous result is still waiting to be taken, so a new
// request is not taken until the last one is finished, even when the
// consumer keeps out_ready high. The result gives rdata for reads (zero
// otherwise) and timer_irq, set when TIMA was reloaded from TMA in the tick.
// The timer advances on a falling edge of divider bit 9, 3, 5 or 7 as
// chosen by TAC[1:0], gated by TAC[2]; an overflow reloads TIMA one
// machine cycle later.
module divider_timer_overflow_irq (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  func,
  input  logic [3:0]  tick_count,
  input  logic [15:0] wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  rdata,
  output logic        timer_irq
);

  dtoi_pkg::cmd_t cmd;
  logic           accept;
  logic           done;
  logic           out_free;
  logic [7:0]     core_rdata;
  logic           step_irq;
  logic           irq_acc;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;

  dtoi_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .tick_count (tick_count),
    .wdata      (wdata),
    .out_free   (out_free),
    .accept     (accept),
    .done       (done),
    .cmd        (cmd)
  );

  dtoi_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rdata    (core_rdata),
    .step_irq (step_irq)
  );

  // interrupt seen over the machine cycles of the current tick
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_acc <= 1'b0;
    end else if (accept) begin
      irq_acc <= 1'b0;
    end else if (step_irq) begin
      irq_acc <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload; the sequencer only finishes when this register is free
  always_ff @(posedge clk) begin
    if (done) begin
      rdata     <= core_rdata;
      timer_irq <= irq_acc | step_irq;
    end
  end

endmodule

// File: verif/timer_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the divider/timer block: predicts every result and compares it.
module timer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  func,
  input  logic [3:0]  tick_count,
  input  logic [15:0] wdata,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  rdata,
  input  logic        timer_irq,
  output int          fail_count,
  output int          pending,
  output int          irq_seen,
  output int          compared
);

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } timer_resp_t;

  // Shadow copy of the timer registers
  logic [15:0] div_q;
  logic [7:0]  tima_q;
  logic [7:0]  tma_q;
  logic [7:0]  tac_q;
  logic        prev_in_q;
  logic        reload_due;
  logic        after_reload;

  timer_resp_t resp_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    irq_seen   = 0;
    compared   = 0;
  end

  task automatic report(input string what, input int got, input int want);
    fail_count++;
    $display("[%0t] result %0d: %s is %0h, predicted %0h", $time, compared, what, got, want);
  endtask

  // Selected divider bit, gated by the enable bit of the control byte
  function automatic logic gated_input();
    int pos;
    case (tac_q[1:0])
      dtoi_pkg::SEL_BIT9: pos = 9;
      dtoi_pkg::SEL_BIT3: pos = 3;
      dtoi_pkg::SEL_BIT5: pos = 5;
      default:            pos = 7;
    endcase
    return tac_q[2] && div_q[pos];
  endfunction

  function automatic void detect_fall();
    logic now;
    now = gated_input();
    if (prev_in_q && !now) begin
      tima_q = tima_q + 8'd1;
      if (tima_q == 8'd0) reload_due = 1'b1;
    end
    prev_in_q = now;
  endfunction

  // One machine cycle; returns 1 when a delayed reload fired
  function automatic logic one_mcycle();
    logic fired;
    fired = reload_due;
    if (reload_due) begin
      tima_q       = tma_q;
      reload_due   = 1'b0;
      after_reload = 1'b1;
    end
    div_q = div_q + dtoi_pkg::DivStep;
    detect_fall();
    return fired;
  endfunction

  function automatic timer_resp_t apply_request(input logic [3:0] f, input logic [3:0] n,
                                                input logic [15:0] w);
    timer_resp_t r;
    int          cycles;
    int          i;
    r = '0;
    case (f)
      dtoi_pkg::FUNC_TICK: begin
        cycles = (n > dtoi_pkg::MaxTickCycles) ? dtoi_pkg::MaxTickCycles : n;
        after_reload = 1'b0;
        for (i = 0; i < cycles; i++)
          if (one_mcycle()) r.irq = 1'b1;
      end
      dtoi_pkg::FUNC_RD_DIV:  r.rdata = div_q[15:8];
      dtoi_pkg::FUNC_WR_DIV: begin
        div_q = '0;
        detect_fall();
      end
      dtoi_pkg::FUNC_RD_TIMA: r.rdata = tima_q;
      dtoi_pkg::FUNC_WR_TIMA: begin
        if (!after_reload) begin
          reload_due = 1'b0;
          tima_q     = w[7:0];
        end
      end
      dtoi_pkg::FUNC_RD_TMA:  r.rdata = tma_q;
      dtoi_pkg::FUNC_WR_TMA: begin
        if (after_reload) tima_q = w[7:0];
        tma_q = w[7:0];
      end
      dtoi_pkg::FUNC_RD_TAC:  r.rdata = tac_q;
      dtoi_pkg::FUNC_WR_TAC: begin
        tac_q = w[7:0];
        detect_fall();
      end
      dtoi_pkg::FUNC_SET_CNT: begin
        div_q     = w;
        prev_in_q = gated_input();
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    timer_resp_t want;
    if (rst) begin
      div_q        = '0;
      tima_q       = '0;
      tma_q        = '0;
      tac_q        = '0;
      prev_in_q    = 1'b0;
      reload_due   = 1'b0;
      after_reload = 1'b0;
      resp_due.delete();
    end else begin
      // a result can never leave on the edge its own request enters
      if (out_valid && out_ready) begin
        compared++;
        if (timer_irq) irq_seen++;
        if (resp_due.size() == 0) begin
          report("unrequested result, rdata", rdata, 0);
        end else begin
          want = resp_due.pop_front();
          if (rdata !== want.rdata) report("rdata", rdata, want.rdata);
          if (timer_irq !== want.irq) report("timer_irq", timer_irq, want.irq);
        end
      end
      if (in_valid && in_ready)
        resp_due.push_back(apply_request(func, tick_count, wdata));
    end
    pending = resp_due.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for the divider/timer block: clock, reset, request traffic and verdict.
module tb;

  localparam int CycleLimit     = 500000;  // far above the slowest legal run
  localparam int RandomRequests = 1800;
  localparam int HoldOffCycles  = 300;     // long consumer stall, fills the block
  localparam int DrainCycles    = 20;
  localparam int MaxGap         = 12;

  // func codes the block must ignore
  localparam logic [3:0] FuncUnusedLo = 4'd10;
  localparam logic [3:0] FuncUnusedHi = 4'd15;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  func;
  logic [3:0]  tick_count;
  logic [15:0] wdata;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  rdata;
  logic        timer_irq;

  int fail_count;
  int pending;
  int irq_seen;
  int compared;
  int sent;
  int ticks_sent;
  int cyc;

  bit no_gaps;   // both sides run flat out while set
  bit hold_req;  // one-shot request for the long receiver hold-off

  divider_timer_overflow_irq uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .tick_count (tick_count),
    .wdata      (wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rdata      (rdata),
    .timer_irq  (timer_irq)
  );

  timer_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .tick_count (tick_count),
    .wdata      (wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rdata      (rdata),
    .timer_irq  (timer_irq),
    .fail_count (fail_count),
    .pending    (pending),
    .irq_seen   (irq_seen),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk);
      cyc++;
    end
    $display("timeout after %0d cycles, %0d results still outstanding", cyc, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side. Each result waits a random number of cycles with out_ready
  // low, except in flat-out stretches. Once per run the hold-off is long, so
  // the block's result register stays full and in_ready must drop while the
  // sender keeps offering.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        stall    = HoldOffCycles;
        hold_req = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, MaxGap);
      end
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one request after a random gap and hold it until accepted.
  // With no gap, valid stays high straight into the next request.
  task automatic push(input logic [3:0] f, input logic [3:0] n, input logic [15:0] w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    func       <= f;
    tick_count <= n;
    wdata      <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
    if (f == dtoi_pkg::FUNC_TICK) ticks_sent++;
  endtask

  // Stop offering until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Random request, weighted toward timer activity: ticks most often, the timer
  // enabled most of the time, and TIMA/TMA loaded near the top so overflows,
  // reloads and accesses right after a reload come often. Upper wdata bits and
  // tick_count on accesses stay random so every input bit toggles.
  task automatic random_request();
    logic [3:0]  f;
    logic [3:0]  n;
    logic [15:0] w;
    int          roll;
    int          pick;
    roll = $urandom_range(0, 99);
    w    = 16'($urandom);
    n    = 4'($urandom);
    if (roll < 45) begin
      f    = dtoi_pkg::FUNC_TICK;
      pick = $urandom_range(0, 9);
      if (pick == 0)      n = 4'd0;                         // zero-length tick
      else if (pick == 1) n = 4'($urandom_range(9, 15));    // saturates
      else                n = 4'($urandom_range(1, dtoi_pkg::MaxTickCycles));
    end else if (roll < 60) begin
      case ($urandom_range(0, 3))
        0:       f = dtoi_pkg::FUNC_RD_DIV;
        1:       f = dtoi_pkg::FUNC_RD_TIMA;
        2:       f = dtoi_pkg::FUNC_RD_TMA;
        default: f = dtoi_pkg::FUNC_RD_TAC;
      endcase
    end else if (roll < 70) begin
      f = dtoi_pkg::FUNC_WR_TIMA;
      if ($urandom_range(0, 3) != 0) w[7:0] = 8'($urandom_range(8'hF0, 8'hFF));
    end else if (roll < 78) begin
      f = dtoi_pkg::FUNC_WR_TMA;
      if ($urandom_range(0, 1) != 0) w[7:0] = 8'($urandom_range(8'hF0, 8'hFF));
    end else if (roll < 86) begin
      f = dtoi_pkg::FUNC_WR_TAC;
      if ($urandom_range(0, 3) != 0) w[2] = 1'b1;
    end else if (roll < 92) begin
      f = dtoi_pkg::FUNC_WR_DIV;
    end else if (roll < 98) begin
      f = dtoi_pkg::FUNC_SET_CNT;
    end else begin
      f = 4'($urandom_range(FuncUnusedLo, FuncUnusedHi));
    end
    push(f, n, w);
  endtask

  initial begin
    int i;
    rst        = 1'b1;
    in_valid   = 1'b0;
    func       = dtoi_pkg::FUNC_TICK;
    tick_count = 4'd0;
    wdata      = 16'd0;
    no_gaps    = 1'b0;
    hold_req   = 1'b0;
    sent       = 0;
    ticks_sent = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset values, then a fast timer driven through an overflow,
    // the accesses right after the reload, tick length extremes, divider
    // loads and clears, control writes that make an edge, unused codes.
    push(dtoi_pkg::FUNC_RD_DIV,  4'd0,  16'h0000);
    push(dtoi_pkg::FUNC_RD_TIMA, 4'hF,  16'hFFFF);
    push(dtoi_pkg::FUNC_RD_TMA,  4'd0,  16'h0000);
    push(dtoi_pkg::FUNC_RD_TAC,  4'd0,  16'h0000);
    push(dtoi_pkg::FUNC_WR_TAC,  4'd0,  16'hA505);   // enabled, divider bit 3
    push(dtoi_pkg::FUNC_RD_TAC,  4'd0,  16'h0000);
    push(dtoi_pkg::FUNC_WR_TMA,  4'd0,  16'h5AFE);
    push(dtoi_pkg::FUNC_WR_TIMA, 4'd0,  16'h00FF);
    push(dtoi_pkg::FUNC_TICK,    4'd8,  16'h0000);   // overflow, reload, interrupt
    push(dtoi_pkg::FUNC_WR_TIMA, 4'd0,  16'h0012);   // dropped: just reloaded
    push(dtoi_pkg::FUNC_WR_TMA,  4'd0,  16'h0034);   // lands in TIMA as well
    push(dtoi_pkg::FUNC_RD_TIMA, 4'd0,  16'h0000);
    push(dtoi_pkg::FUNC_TICK,    4'd0,  16'h0000);   // only clears the reload flag
    push(dtoi_pkg::FUNC_TICK,    4'hF,  16'h0000);   // capped at the maximum tick length
    push(dtoi_pkg::FUNC_SET_CNT, 4'd0,  16'hFFFF);
    push(dtoi_pkg::FUNC_WR_DIV,  4'd0,  16'hFFFF);   // clearing makes a falling edge
    push(dtoi_pkg::FUNC_SET_CNT, 4'd0,  16'h0008);
    push(dtoi_pkg::FUNC_WR_TAC,  4'd0,  16'h00F8);   // disable drops the input
    push(dtoi_pkg::FUNC_WR_TAC,  4'd0,  16'h0007);
    push(dtoi_pkg::FUNC_WR_TAC,  4'd0,  16'h0006);
    push(dtoi_pkg::FUNC_RD_DIV,  4'd0,  16'h0000);
    push(FuncUnusedLo,           4'hF,  16'hFFFF);
    push(FuncUnusedHi,           4'hF,  16'hFFFF);
    push(dtoi_pkg::FUNC_WR_TIMA, 4'd0,  16'h00FF);
    push(dtoi_pkg::FUNC_TICK,    4'd1,  16'h0000);

    // Random phase with flat-out stretches, one long receiver stall and one
    // full drain in the middle.
    for (i = 0; i < RandomRequests; i++) begin
      if (i % 150 == 100) no_gaps = 1'b1;
      if (i % 150 == 140) no_gaps = 1'b0;
      if (i == 400) hold_req = 1'b1;
      if (i == 900) drain();
      random_request();
    end

    drain();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d requests (%0d ticks, every operation and the unused codes).",
             sent, ticks_sent);
    $display("Compared %0d results, %0d of them with the timer interrupt set.",
             compared, irq_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
